// ===== sv/stt_pkg.sv =====
package stt_pkg;

	// Default sizes of the table
	localparam int NUM_TIMERS_DEF   = 16;
	localparam int LENGTH_WIDTH_DEF = 16;

	// Width of the per-timer masks on the ports
	localparam int MASK_W = 16;

	// Command codes
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_RESTART = 2'd1,
		OP_CLOSE   = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	// Timer modes; periodic and the spare code both keep the timer on
	localparam logic [1:0] MODE_ONCE    = 2'd0;
	localparam logic [1:0] MODE_STOP_OK = 2'd2;

	// Status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DRAIN,
		ST_RESP
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic exec;
		logic walk;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic walk_last;
	} dp_stat_t;

endpackage

// ===== sv/stt_ctrl.sv =====
module stt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       op,
	input  stt_pkg::dp_stat_t stat,
	output stt_pkg::ctrl_cmd_t cmd,
	output logic             busy,
	output logic             done
);
	import stt_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (op == OP_TICK) ? ST_WALK : ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_WALK: begin
				if (stat.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.latch = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
			end
			ST_DRAIN: begin
				cmd = '0;
			end
			ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/stt_datapath.sv =====
module stt_datapath #(
	parameter int NUM_TIMERS   = 16,
	parameter int LENGTH_WIDTH = 16,
	parameter int IDX_W        = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stt_pkg::ctrl_cmd_t         cmd,
	output stt_pkg::dp_stat_t          stat,
	input  logic [1:0]                 op,
	input  logic [7:0]                 timer_index,
	input  logic [15:0]                length,
	input  logic [1:0]                 mode,
	input  logic                       has_handler,
	input  logic [stt_pkg::MASK_W-1:0] success_mask,
	output logic                       status,
	output logic [stt_pkg::MASK_W-1:0] expired_mask
);
	import stt_pkg::*;

	localparam int CFG_W = LENGTH_WIDTH + 3;

	// Latched command word
	op_t                     op_q;
	logic [7:0]              idx_q;
	logic [LENGTH_WIDTH-1:0] len_q;
	logic [1:0]              mode_q;
	logic                    hh_q;
	logic [MASK_W-1:0]       ok_q;

	// Table storage: count and setup per timer, on/loaded bits in flops
	logic [LENGTH_WIDTH-1:0] cnt_mem [NUM_TIMERS];
	logic [CFG_W-1:0]        cfg_mem [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]   running_q;
	logic [NUM_TIMERS-1:0]   loaded_q;

	// Walk control and read stage
	logic [IDX_W-1:0]        walk_idx_q;
	logic                    v_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [LENGTH_WIDTH-1:0] cnt_rd_s1;
	logic [CFG_W-1:0]        cfg_rd_s1;

	logic                    outcome_q;
	logic [MASK_W-1:0]       expired_q;
	logic                    status_q;

	// Command decode
	logic                    idx_ok;
	logic [IDX_W-1:0]        cmd_idx;
	logic                    start_ok;
	logic                    restart_ok;
	logic                    close_ok;
	logic                    reject;

	// Entry update
	logic [LENGTH_WIDTH-1:0] cnt_inc;
	logic [LENGTH_WIDTH-1:0] period_eff;
	logic [1:0]              mode_eff;
	logic                    hh_eff;
	logic                    live;
	logic                    fire;
	logic [7:0]              idx8;
	logic                    low16;
	logic [3:0]              bsel;
	logic                    outcome_nx;
	logic                    stop;

	// Count memory write port
	logic                    cnt_we;
	logic [IDX_W-1:0]        cnt_wa;
	logic [LENGTH_WIDTH-1:0] cnt_wd;

	// Capture the command word on accept
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op_t'(op);
			idx_q  <= timer_index;
			len_q  <= LENGTH_WIDTH'(length);
			mode_q <= mode;
			hh_q   <= has_handler;
			ok_q   <= success_mask;
		end
	end

	// Decode start, restart and close
	always_comb begin
		idx_ok     = idx_q < 8'(NUM_TIMERS);
		cmd_idx    = idx_q[IDX_W-1:0];
		start_ok   = cmd.exec && (op_q == OP_START) && idx_ok && (len_q != '0);
		restart_ok = cmd.exec && (op_q == OP_RESTART) && idx_ok;
		close_ok   = cmd.exec && (op_q == OP_CLOSE) && idx_ok;
		reject     = !idx_ok || ((op_q == OP_START) && (len_q == '0));
	end

	// Update one entry per cycle during a tick; never-loaded entries read as zero
	always_comb begin
		cnt_inc    = cnt_rd_s1 + 1'b1;
		period_eff = loaded_q[idx_s1] ? cfg_rd_s1[CFG_W-1:3] : '0;
		mode_eff   = loaded_q[idx_s1] ? cfg_rd_s1[2:1] : MODE_ONCE;
		hh_eff     = loaded_q[idx_s1] && cfg_rd_s1[0];
		live       = v_s1 && running_q[idx_s1];
		fire       = live && (cnt_inc >= period_eff);
		idx8       = 8'(idx_s1);
		low16      = idx8 < 8'd16;
		bsel       = idx8[3:0];
		// carry the last handler outcome over entries that do not fire with a handler
		outcome_nx = (fire && hh_eff) ? (low16 && ok_q[bsel]) : outcome_q;
		stop       = fire && ((mode_eff == MODE_ONCE) ||
			((mode_eff == MODE_STOP_OK) && outcome_nx));
	end

	// Steer the count write port
	always_comb begin
		cnt_we = start_ok || restart_ok || live;
		cnt_wa = live ? idx_s1 : cmd_idx;
		cnt_wd = (live && !fire) ? cnt_inc : '0;
	end

	// Table memories with registered reads
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (start_ok) begin
			cfg_mem[cmd_idx] <= {len_q, mode_q, hh_q};
		end
		cnt_rd_s1 <= cnt_mem[walk_idx_q];
		cfg_rd_s1 <= cfg_mem[walk_idx_q];
		idx_s1    <= walk_idx_q;
	end

	// Walk counter, outcome, result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_idx_q <= '0;
			v_s1       <= 1'b0;
			outcome_q  <= 1'b0;
			expired_q  <= '0;
			status_q   <= STATUS_OK;
		end else begin
			v_s1 <= cmd.walk;
			if (cmd.latch) begin
				walk_idx_q <= '0;
				outcome_q  <= 1'b0;
				expired_q  <= '0;
				status_q   <= STATUS_OK;
			end else begin
				if (cmd.walk && !stat.walk_last) begin
					walk_idx_q <= walk_idx_q + 1'b1;
				end
				if (cmd.exec) begin
					status_q <= reject ? STATUS_REJECT : STATUS_OK;
				end
				if (live) begin
					outcome_q <= outcome_nx;
				end
				if (fire && low16) begin
					expired_q[bsel] <= 1'b1;
				end
			end
		end
	end

	// On and loaded bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			loaded_q  <= '0;
		end else begin
			if (start_ok || restart_ok) begin
				running_q[cmd_idx] <= 1'b1;
			end
			if (close_ok) begin
				running_q[cmd_idx] <= 1'b0;
			end
			if (live && stop) begin
				running_q[idx_s1] <= 1'b0;
			end
			if (start_ok) begin
				loaded_q[cmd_idx] <= 1'b1;
			end
		end
	end

	assign stat.walk_last = walk_idx_q == IDX_W'(NUM_TIMERS - 1);
	assign status         = status_q;
	assign expired_mask   = expired_q;

endmodule

// ===== sv/software_timer_table_unit.sv =====
// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+-------------------------
// command  | op, timer_index, length, mode, has_handler,      | taken when start && !busy
//          | success_mask                                     |
// result   | status, expired_mask                             | one-cycle strobe done
//
// Start, restart and close go through accept, execute and result before the next
// accept. A tick goes through accept, a walk, a drain state and result: the walk
// reads one table entry per cycle and writes it back through the shared count-memory
// write port after the registered read. busy is high after accept through the result
// cycle. Reset clears the on and loaded bits at once; there is no clearing pass.
// The receiver cannot stall; done is high for exactly one cycle per word.
module software_timer_table_unit #(
	parameter int NUM_TIMERS   = stt_pkg::NUM_TIMERS_DEF,
	parameter int LENGTH_WIDTH = stt_pkg::LENGTH_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 op,
	input  logic [7:0]                 timer_index,
	input  logic [15:0]                length,
	input  logic [1:0]                 mode,
	input  logic                       has_handler,
	input  logic [stt_pkg::MASK_W-1:0] success_mask,
	output logic                       done,
	output logic                       status,
	output logic [stt_pkg::MASK_W-1:0] expired_mask
);
	import stt_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequence commands and the table walk
	stt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold the table and update entries
	stt_datapath #(
		.NUM_TIMERS   (NUM_TIMERS),
		.LENGTH_WIDTH (LENGTH_WIDTH),
		.IDX_W        (IDX_W)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.timer_index  (timer_index),
		.length       (length),
		.mode         (mode),
		.has_handler  (has_handler),
		.success_mask (success_mask),
		.status       (status),
		.expired_mask (expired_mask)
	);

endmodule

// ===== sv/stt_checker.sv =====
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  op,
	input logic        done,
	input logic        status,
	input logic [15:0] expired_mask
);
	import stt_pkg::*;

	// Accept makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accept");

	// A word appears only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word while idle");

	// A result word lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// Non-tick commands answer after the execute state, with no expired bits
	a_cmd_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op != OP_TICK) |=> ##1 (done && (expired_mask == '0)))
		else $error("command result late or carries expired bits");

	// A rejected word never reports expired timers
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_REJECT) |-> (expired_mask == '0))
		else $error("rejected word with expired bits");

endmodule

bind software_timer_table_unit stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.op           (op),
	.done         (done),
	.status       (status),
	.expired_mask (expired_mask)
);

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int N_TMR       = NUM_TIMERS_DEF;
	localparam int LEN_W       = LENGTH_WIDTH_DEF;
	localparam int TICK_CYCLES = N_TMR + 3;
	localparam int MAX_REPORTS = 10;

	// Modes that the package leaves unnamed
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_SPARE    = 2'd3;

	typedef struct packed {
		logic              status;
		logic [MASK_W-1:0] expired;
	} timer_word_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	op_t               op;
	logic [7:0]        timer_index;
	logic [15:0]       length;
	logic [1:0]        mode;
	logic              has_handler;
	logic [MASK_W-1:0] success_mask;
	logic              done;
	logic              status;
	logic [MASK_W-1:0] expired_mask;

	// Shadow copy of the timer table
	logic [LEN_W-1:0] tmr_len  [N_TMR];
	logic [LEN_W-1:0] tmr_cnt  [N_TMR];
	logic [1:0]       tmr_mode [N_TMR];
	logic             tmr_hnd  [N_TMR];
	logic             tmr_on   [N_TMR];

	timer_word_t pending_words[$];

	int  mismatches;
	int  words_checked;
	int  cmds_sent;
	int  ticks_sent;
	int  rejects_seen;
	int  expiries_seen;
	bit  calm;

	software_timer_table_unit #(
		.NUM_TIMERS  (N_TMR),
		.LENGTH_WIDTH(LEN_W)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.timer_index (timer_index),
		.length      (length),
		.mode        (mode),
		.has_handler (has_handler),
		.success_mask(success_mask),
		.done        (done),
		.status      (status),
		.expired_mask(expired_mask)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one command to the shadow table and return the word it should produce
	function automatic timer_word_t table_update(op_t c, logic [7:0] idx, logic [15:0] len,
			logic [1:0] md, logic hh, logic [MASK_W-1:0] ok);
		timer_word_t      w;
		logic             outcome;
		logic [LEN_W-1:0] l;
		int               k;
		w         = '0;
		w.status  = STATUS_OK;
		l         = len[LEN_W-1:0];
		outcome   = 1'b0;
		case (c)
			OP_START: begin
				if (idx < N_TMR && l != '0) begin
					tmr_len[idx]  = l;
					tmr_cnt[idx]  = '0;
					tmr_mode[idx] = md;
					tmr_hnd[idx]  = hh;
					tmr_on[idx]   = 1'b1;
				end else begin
					w.status = STATUS_REJECT;
				end
			end
			OP_RESTART: begin
				if (idx < N_TMR) begin
					tmr_on[idx]  = 1'b1;
					tmr_cnt[idx] = '0;
				end else begin
					w.status = STATUS_REJECT;
				end
			end
			OP_CLOSE: begin
				if (idx < N_TMR)
					tmr_on[idx] = 1'b0;
				else
					w.status = STATUS_REJECT;
			end
			default: begin
				// Walk in index order; the handler outcome carries across entries
				for (k = 0; k < N_TMR; k++) begin
					if (tmr_on[k]) begin
						tmr_cnt[k] = tmr_cnt[k] + 1'b1;
						if (tmr_cnt[k] >= tmr_len[k]) begin
							tmr_cnt[k] = '0;
							if (k < MASK_W)
								w.expired[k] = 1'b1;
							if (tmr_hnd[k])
								outcome = (k < MASK_W) ? ok[k] : 1'b0;
							if (tmr_mode[k] == MODE_ONCE)
								tmr_on[k] = 1'b0;
							else if (tmr_mode[k] == MODE_STOP_OK && outcome)
								tmr_on[k] = 1'b0;
						end
					end
				end
			end
		endcase
		return w;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// Check every result word against the oldest prediction
	always @(posedge clk) begin : check_words
		timer_word_t want;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				note_mismatch($sformatf("unexpected word: status %0b expired %h",
					status, expired_mask));
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (status !== want.status)
					note_mismatch($sformatf("status: expected %0b, got %0b",
						want.status, status));
				if (expired_mask !== want.expired)
					note_mismatch($sformatf("expired_mask: expected %h, got %h",
						want.expired, expired_mask));
			end
		end
	end

	// Drive one command and hold it until the block takes it
	task automatic send_word(op_t c, logic [7:0] idx, logic [15:0] len, logic [1:0] md,
			logic hh, logic [MASK_W-1:0] ok);
		timer_word_t w;
		op           = c;
		timer_index  = idx;
		length       = len;
		mode         = md;
		has_handler  = hh;
		success_mask = ok;
		start        = 1'b1;
		do
			@(posedge clk);
		while (busy);
		w = table_update(c, idx, len, md, hh, ok);
		pending_words.push_back(w);
		cmds_sent++;
		if (c == OP_TICK)
			ticks_sent++;
		if (w.status == STATUS_REJECT)
			rejects_seen++;
		expiries_seen += $countones(w.expired);
		@(negedge clk);
	endtask

	// Idle the sender for a random burst now and then while not calm, with junk on the fields
	task automatic hold_off();
		if (!calm && $urandom_range(0, 2) == 0) begin
			start        = 1'b0;
			op           = op_t'($urandom_range(0, 3));
			timer_index  = 8'($urandom);
			length       = 16'($urandom);
			success_mask = MASK_W'($urandom);
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		start = 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_rejects();
		send_word(OP_START, 8'(N_TMR), 16'd5, MODE_ONCE, 1'b1, '0);
		hold_off();
		send_word(OP_START, 8'hFF, 16'hFFFF, MODE_PERIODIC, 1'b0, '1);
		send_word(OP_START, 8'd0, 16'd0, MODE_STOP_OK, 1'b1, '0);
		hold_off();
		send_word(OP_RESTART, 8'hFF, 16'd1, MODE_ONCE, 1'b0, '0);
		send_word(OP_CLOSE, 8'(N_TMR), 16'd1, MODE_ONCE, 1'b0, '0);
	endtask

	// A restarted entry that was never loaded has length zero, fires on the next tick and then stops as a one-shot
	task automatic test_unloaded_restart();
		send_word(OP_RESTART, 8'(N_TMR - 1), 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_TICK, 8'd0, 16'd0, MODE_ONCE, 1'b0, '0);
		hold_off();
		send_word(OP_TICK, 8'hA5, 16'h5A5A, MODE_SPARE, 1'b1, '1);
		send_word(OP_CLOSE, 8'(N_TMR - 1), 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_TICK, 8'd0, 16'd0, MODE_ONCE, 1'b0, '0);
	endtask

	// Cover every mode, the outcome carry-over and the longest length
	task automatic test_modes();
		send_word(OP_START, 8'd0, 16'd1, MODE_ONCE, 1'b1, '0);
		send_word(OP_START, 8'd1, 16'd2, MODE_PERIODIC, 1'b0, '0);
		send_word(OP_START, 8'd2, 16'd1, MODE_STOP_OK, 1'b1, '0);
		hold_off();
		send_word(OP_START, 8'd3, 16'd1, MODE_SPARE, 1'b0, '0);
		send_word(OP_START, 8'd4, 16'd1, MODE_STOP_OK, 1'b0, '0);
		send_word(OP_START, 8'd5, 16'hFFFF, MODE_PERIODIC, 1'b1, '0);
		send_word(OP_TICK, 8'd0, 16'd0, MODE_ONCE, 1'b0, '1);
		hold_off();
		send_word(OP_TICK, 8'd0, 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_TICK, 8'd0, 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_CLOSE, 8'd1, 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_CLOSE, 8'd3, 16'd0, MODE_ONCE, 1'b0, '0);
		send_word(OP_CLOSE, 8'd5, 16'd0, MODE_ONCE, 1'b0, '0);
	endtask

	// Mostly valid commands on short timers so that entries keep expiring
	task automatic test_random_traffic(int count);
		int          pick;
		int          len_pick;
		op_t         c;
		logic [7:0]  idx;
		logic [15:0] len;
		logic [1:0]  md;
		repeat (count) begin
			pick     = $urandom_range(0, 99);
			len_pick = $urandom_range(0, 19);
			if (pick < 40)
				c = OP_TICK;
			else if (pick < 70)
				c = OP_START;
			else if (pick < 85)
				c = OP_RESTART;
			else
				c = OP_CLOSE;
			if ($urandom_range(0, 9) == 0)
				idx = 8'($urandom_range(N_TMR, 255));
			else
				idx = 8'($urandom_range(0, N_TMR - 1));
			if (len_pick == 0)
				len = '0;
			else if (len_pick < 3)
				len = 16'($urandom_range(0, 65535));
			else
				len = 16'($urandom_range(1, 6));
			if ($urandom_range(0, 7) == 0)
				md = MODE_SPARE;
			else
				md = 2'($urandom_range(0, 2));
			send_word(c, idx, len, md, 1'($urandom_range(0, 1)), MASK_W'($urandom));
			hold_off();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_START;
		timer_index  = '0;
		length       = '0;
		mode         = MODE_ONCE;
		has_handler  = 1'b0;
		success_mask = '0;
		calm         = 1'b0;
		mismatches   = 0;
		for (int k = 0; k < N_TMR; k++) begin
			tmr_len[k]  = '0;
			tmr_cnt[k]  = '0;
			tmr_mode[k] = MODE_ONCE;
			tmr_hnd[k]  = 1'b0;
			tmr_on[k]   = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_rejects();
		test_unloaded_restart();
		test_modes();
		test_random_traffic(250);
		// Let the block go fully idle once mid-run
		wait_for_results();
		test_random_traffic(150);
		calm = 1'b1;
		test_random_traffic(100);

		wait_for_results();
		repeat (TICK_CYCLES + 4) @(negedge clk);
		$display("Sent %0d commands (%0d ticks), %0d rejected, %0d timer expiries;",
			cmds_sent, ticks_sent, rejects_seen, expiries_seen);
		$display("checked %0d result words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
